/* hw/rtl/alc_pkg.sv */
// Shared types, constants and constant tables for the alcohol sensor converter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package alc_pkg;

  localparam int unsigned SampleCountDef = 8;
  localparam int unsigned AdcMaxDef      = 1023;

  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 16;
  localparam int unsigned R0W     = 24;
  localparam int unsigned RlW     = 20;
  localparam int unsigned FieldW  = 24;
  localparam int unsigned NumW    = 36;   // ADC_MAX * N * load fits in 36 bits
  localparam int unsigned DivW    = 52;   // widest dividend: rs << 16
  localparam int unsigned DivisorW = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CLEAN_AIR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOAD      = 2'd1;

  localparam logic [R0W-1:0] R0_RESET = 24'd60000;
  localparam logic [RlW-1:0] RL_RESET = 20'd200000;

  localparam logic [FieldW-1:0] MAX24 = 24'hFFFFFF;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // log2(4.7) and 1.11 in Q16, offset of eight octaves for the exp2 stage.
  localparam logic signed [25:0] LOG2_COEFF = 26'sd146320;
  localparam logic signed [25:0] Z_OFFSET   = 26'sd524288;
  localparam logic signed [25:0] Z_LIMIT    = 26'sd2621440;
  localparam logic signed [17:0] EXPONENT   = 18'sd72745;

  // Reciprocals of 125 for the mg/L and blood alcohol scaling. For a ppm value
  // below 2^26, (ppm * MG_RECIP) >> 33 is floor(ppm * 64 / 125) and
  // (ppm * BAC_RECIP) >> 33 is floor(ppm * 128 / 125), both exact.
  localparam logic [33:0] MG_RECIP  = 34'd4398046512;
  localparam logic [33:0] BAC_RECIP = 34'd8796093023;

  typedef struct packed {
    logic [FieldW-1:0] rs_ohms;
    logic [FieldW-1:0] ratio_q16;
    logic [FieldW-1:0] ppm_q8;
    logic [FieldW-1:0] mg_per_litre_q16;
    logic [FieldW-1:0] blood_alcohol_q16;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  // Integer square root of a 64-bit value, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Entry i holds 2^(2^-(i+1)) in Q1.30, each from the previous by a square root.
  function automatic logic [16*31-1:0] exp_table();
    logic [63:0]        f;
    logic [16*31-1:0]   tbl;
    f   = 64'd2 << 30;
    tbl = '0;
    for (int k = 0; k < 16; k++) begin
      f = isqrt64(f << 30);
      tbl[k*31 +: 31] = f[30:0];
    end
    return tbl;
  endfunction

  localparam logic [16*31-1:0] EXP_TABLE = exp_table();

endpackage
`default_nettype wire

/* hw/rtl/alc_front.sv */
// Front end: accumulates raw samples and posts each finished sum to the queue.
// Depends on alc_pkg.
`default_nettype none
module alc_front #(
  parameter int unsigned SAMPLE_COUNT = alc_pkg::SampleCountDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [alc_pkg::SampleW-1:0] sample_i,
  output logic                            push_o,
  output logic [alc_pkg::SumW-1:0]        sum_o
);
  localparam int unsigned CntW = $clog2(SAMPLE_COUNT + 1);

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [alc_pkg::SumW-1:0] sum_q, sum_d, sum_next;
  logic                     last;

  assign sum_next = sum_q + alc_pkg::SumW'(sample_i);
  assign last     = (cnt_q == CntW'(SAMPLE_COUNT - 1));
  assign push_o   = accept_i && last;
  assign sum_o    = sum_next;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (accept_i) begin
      if (last) begin
        cnt_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        sum_d = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/alc_fifo.sv */
// Two-entry queue of sample sums between the front end and the sequencer.
// Depends on alc_pkg.
`default_nettype none
module alc_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [alc_pkg::SumW-1:0]  data_i,
  input  wire logic                      pop_i,
  output logic [alc_pkg::SumW-1:0]       data_o,
  output logic                           full_o,
  output logic                           empty_o
);
  logic [alc_pkg::SumW-1:0] mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/alc_div.sv */
// Restoring serial divider, one quotient bit per cycle, shared by all divisions.
// Depends on alc_pkg.
`default_nettype none
module alc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire alc_pkg::div_req_t req_i,
  output alc_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned DW = alc_pkg::DivW;
  localparam int unsigned VW = alc_pkg::DivisorW;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial;
  logic          take;

  assign trial = {rem_q, quo_q[DW-1]};
  assign take  = (trial >= {1'b0, dvs_q});
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], take};
      rem_q <= take ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/alc_back.sv */
// Back end sequencer: resistance, ratio, log2, power law, exp2 and scaling.
// Depends on alc_pkg and alc_div.
`default_nettype none
module alc_back #(
  parameter int unsigned SAMPLE_COUNT = alc_pkg::SampleCountDef,
  parameter int unsigned ADC_MAX      = alc_pkg::AdcMaxDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [alc_pkg::R0W-1:0]    r0_i,
  input  wire logic [alc_pkg::RlW-1:0]    rl_i,
  input  wire logic                       q_empty_i,
  input  wire logic [alc_pkg::SumW-1:0]   q_data_i,
  output logic                            q_pop_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output alc_pkg::result_t                res_o
);
  localparam logic [15:0] ADC_N = 16'(ADC_MAX * SAMPLE_COUNT);
  localparam int unsigned NW = alc_pkg::NumW;
  localparam int unsigned DW = alc_pkg::DivW;

  localparam logic [3:0] S_IDLE = 4'd0,  S_MUL  = 4'd1,  S_RS   = 4'd2,  S_RSW = 4'd3,
                         S_RATW = 4'd4,  S_NORM = 4'd5,  S_LOG  = 4'd6,  S_LMUL = 4'd7,
                         S_Z    = 4'd8,  S_ZC   = 4'd9,  S_EXP  = 4'd10, S_SHIFT = 4'd11,
                         S_MG   = 4'd12, S_MGW  = 4'd13, S_BACW = 4'd14, S_DONE = 4'd15;

  logic [3:0]  state_q;
  logic [3:0]  cnt_q;
  logic [alc_pkg::SumW-1:0] s_q;
  logic [NW-1:0] num_q, sub_q, rs_q;
  logic [DW-1:0] ratio_q, n_q;
  logic [5:0]  e_q;
  logic [31:0] m_q;
  logic [15:0] frac_q;
  logic signed [40:0] t_q;
  logic signed [25:0] z_q;
  logic [30:0] p_q;
  logic [39:0] ppm_q;
  logic [32:0] mg_q, bac_q;
  logic zero_q, neg_q, big_q, mgsat_q;
  alc_pkg::div_req_t div_req;
  alc_pkg::div_rsp_t div_rsp;

  // Combinational helpers for the current step.
  logic [63:0] sq;
  logic [32:0] sq_t;
  logic signed [6:0]  e_signed;
  logic signed [22:0] lval;
  logic [40:0] t_abs;
  logic signed [25:0] rnd, z_calc;
  logic [30:0] factor;
  logic [61:0] prod;
  logic [5:0]  ip;
  logic [39:0] ppm_calc;
  logic [33:0] recip;
  logic [59:0] scale_prod;

  assign sq       = m_q * m_q;
  assign sq_t     = sq[63:31];
  assign e_signed = $signed({1'b0, e_q}) - 7'sd16;
  assign lval     = {e_signed, frac_q};
  assign t_abs    = t_q[40] ? 41'(-t_q) : 41'(t_q);
  assign rnd      = t_q[40] ? -$signed(26'((t_abs + 41'd32768) >> 16))
                            :  $signed(26'((t_abs + 41'd32768) >> 16));
  assign z_calc   = alc_pkg::LOG2_COEFF - rnd + alc_pkg::Z_OFFSET;
  assign factor   = alc_pkg::EXP_TABLE[cnt_q*31 +: 31];
  assign prod     = p_q * factor;
  assign ip       = z_q[21:16];
  assign ppm_calc = ({9'd0, p_q} << 9) >> (6'd39 - ip);

  // Division by 125 as a multiplication by its reciprocal, one field per cycle.
  assign recip      = (state_q == S_BACW) ? alc_pkg::BAC_RECIP : alc_pkg::MG_RECIP;
  assign scale_prod = 60'(ppm_q[25:0]) * 60'(recip);

  alc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign res_valid_o = (state_q == S_DONE);

  function automatic logic [alc_pkg::FieldW-1:0] sat24(input logic [DW-1:0] v);
    return (v > DW'(alc_pkg::MAX24)) ? alc_pkg::MAX24 : v[alc_pkg::FieldW-1:0];
  endfunction

  always_comb begin
    res_o = '0;
    if (zero_q) begin
      res_o.rs_ohms   = alc_pkg::MAX24;
      res_o.ratio_q16 = alc_pkg::MAX24;
      res_o.status    = alc_pkg::ST_ZERO;
    end else begin
      res_o.rs_ohms   = sat24(DW'(rs_q));
      res_o.ratio_q16 = sat24(ratio_q);
      if (big_q || mgsat_q) begin
        res_o.ppm_q8            = big_q ? alc_pkg::MAX24 : sat24(DW'(ppm_q));
        res_o.mg_per_litre_q16  = alc_pkg::MAX24;
        res_o.blood_alcohol_q16 = alc_pkg::MAX24;
      end else begin
        res_o.ppm_q8            = sat24(DW'(ppm_q));
        res_o.mg_per_litre_q16  = sat24(DW'(mg_q));
        res_o.blood_alcohol_q16 = sat24(DW'(bac_q));
      end
      res_o.status = (neg_q || big_q || mgsat_q || rs_q > NW'(alc_pkg::MAX24)
                      || ratio_q > DW'(alc_pkg::MAX24) || ppm_q > 40'(alc_pkg::MAX24)
                      || mg_q > 33'(alc_pkg::MAX24) || bac_q > 33'(alc_pkg::MAX24))
                     ? alc_pkg::ST_SAT : alc_pkg::ST_OK;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_RS: begin
        div_req.start    = (num_q >= sub_q);
        div_req.dividend = DW'(num_q - sub_q);
        div_req.divisor  = alc_pkg::DivisorW'(s_q);
      end
      S_RSW: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {div_rsp.quotient[NW-1:0], 16'd0};
        div_req.divisor  = (r0_i == '0) ? alc_pkg::DivisorW'(1) : r0_i;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        s_q     <= q_data_i;
        neg_q   <= 1'b0;
        big_q   <= 1'b0;
        mgsat_q <= 1'b0;
        zero_q  <= (q_data_i == '0);
        rs_q    <= '0;
        ratio_q <= '0;
        ppm_q   <= '0;
        mg_q    <= '0;
        bac_q   <= '0;
      end
      S_MUL: begin
        num_q <= NW'(ADC_N) * NW'(rl_i);
        sub_q <= NW'(rl_i) * NW'(s_q);
      end
      S_RS: begin
        if (num_q < sub_q) begin
          neg_q <= 1'b1;
          big_q <= 1'b1;
        end
      end
      S_RSW: if (div_rsp.done) rs_q <= div_rsp.quotient[NW-1:0];
      S_RATW: begin
        if (div_rsp.done) begin
          ratio_q <= div_rsp.quotient;
          n_q     <= div_rsp.quotient;
          e_q     <= 6'(DW - 1);
          if (div_rsp.quotient == '0) big_q <= 1'b1;
        end
      end
      S_NORM: begin
        if (n_q[DW-1]) begin
          m_q    <= n_q[DW-1 -: 32];
          cnt_q  <= '0;
          frac_q <= '0;
        end else begin
          n_q <= {n_q[DW-2:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
      end
      S_LOG: begin
        m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_q <= {frac_q[14:0], sq_t[32]};
        cnt_q  <= cnt_q + 4'd1;
      end
      S_LMUL: t_q <= lval * alc_pkg::EXPONENT;
      S_Z:    z_q <= z_calc;
      S_ZC: begin
        p_q   <= 31'h40000000;
        cnt_q <= '0;
        if (z_q >= alc_pkg::Z_LIMIT) big_q <= 1'b1;
      end
      S_EXP: begin
        if (z_q[4'd15 - cnt_q]) p_q <= prod[60:30];
        cnt_q <= cnt_q + 4'd1;
      end
      S_SHIFT: ppm_q <= ppm_calc;
      S_MG: if (ppm_q >= 40'd67108864) mgsat_q <= 1'b1;
      S_MGW:  mg_q  <= 33'(scale_prod[59:33]);
      S_BACW: bac_q <= 33'(scale_prod[59:33]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (!q_empty_i) state_q <= (q_data_i == '0) ? S_DONE : S_MUL;
        S_MUL:  state_q <= S_RS;
        S_RS:   state_q <= (num_q < sub_q) ? S_DONE : S_RSW;
        S_RSW:  if (div_rsp.done) state_q <= S_RATW;
        S_RATW: if (div_rsp.done) state_q <= (div_rsp.quotient == '0) ? S_DONE : S_NORM;
        S_NORM: if (n_q[DW-1]) state_q <= S_LOG;
        S_LOG:  if (cnt_q == 4'd15) state_q <= S_LMUL;
        S_LMUL: state_q <= S_Z;
        S_Z:    state_q <= S_ZC;
        S_ZC: begin
          if (z_q >= alc_pkg::Z_LIMIT) state_q <= S_DONE;
          else if (z_q < 0)            state_q <= S_MG;
          else                         state_q <= S_EXP;
        end
        S_EXP:   if (cnt_q == 4'd15) state_q <= S_SHIFT;
        S_SHIFT: state_q <= S_MG;
        S_MG:    state_q <= (ppm_q >= 40'd67108864) ? S_DONE : S_MGW;
        S_MGW:   state_q <= S_BACW;
        S_BACW:  state_q <= S_DONE;
        S_DONE:  if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/gas_sensor_alcohol_converter.sv */
// Top level of the alcohol gas-sensor converter: ports, configuration and result register.
// Depends on alc_pkg, alc_front, alc_fifo and alc_back.
//
// The block sums SAMPLE_COUNT raw converter samples and, after the last one, produces one
// result: sensor resistance, ratio to the clean-air resistance, concentration in ppm from
// the power law 4.7*ratio^-1.11, mg/L and blood alcohol, all saturated to 24 bits, plus a
// status code (0 ok, 1 zero sample sum, 2 some field saturated). The front end posts every
// finished sum into a two-entry queue; the back end evaluates one sum at a time (two passes
// of the serial divider, a normalization, 16 log2 squaring steps, 16 exp2 steps and the
// remaining steps, the mg/L and blood alcohol scaling among them), and the input stalls
// only when both queue entries are waiting. A finished result sits in an output register
// while the back end starts on the next sum. The user must write the registers only while
// the block is idle; the block itself does not enforce this.
`default_nettype none
module gas_sensor_alcohol_converter #(
  parameter int unsigned SAMPLE_COUNT = alc_pkg::SampleCountDef,
  parameter int unsigned ADC_MAX      = alc_pkg::AdcMaxDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [15:0]   s_axis_tdata,   // [9:0] adc_sample
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [23:0] rs_ohms, [47:24] ratio_q16, [71:48] ppm_q8, [95:72] mg_per_litre_q16,
  // [119:96] blood_alcohol_q16, [121:120] status
  output logic [127:0]       m_axis_tdata,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [alc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [23:0]   cfg_data_i
);
  logic [alc_pkg::R0W-1:0]  r0_q;
  logic [alc_pkg::RlW-1:0]  rl_q;
  logic                     in_accept, push, pop, q_full, q_empty;
  logic [alc_pkg::SumW-1:0] push_sum, q_data;
  logic                     res_valid, res_ready;
  alc_pkg::result_t         res, out_q;
  logic                     out_valid_q;

  // Configuration is always accepted; unknown indices are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= alc_pkg::R0_RESET;
      rl_q <= alc_pkg::RL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        alc_pkg::CFG_CLEAN_AIR: r0_q <= cfg_data_i;
        alc_pkg::CFG_LOAD:      rl_q <= cfg_data_i[alc_pkg::RlW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input stalls only when the queue of pending sums is full.
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  alc_front #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .sample_i (s_axis_tdata[alc_pkg::SampleW-1:0]),
    .push_o   (push),
    .sum_o    (push_sum)
  );

  alc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_sum),
    .pop_i   (pop),
    .data_o  (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  alc_back #(.SAMPLE_COUNT(SAMPLE_COUNT), .ADC_MAX(ADC_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .r0_i        (r0_q),
    .rl_i        (rl_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: the back end may hand over a new result whenever the slot is
  // empty or its content is being transferred in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.blood_alcohol_q16,
                          out_q.mg_per_litre_q16, out_q.ppm_q8, out_q.ratio_q16,
                          out_q.rs_ohms};
endmodule
`default_nettype wire

/* tb/gas_sensor_alcohol_converter_tb.sv */
// Self-checking testbench for the alcohol gas-sensor converter.
// Depends on alc_pkg and gas_sensor_alcohol_converter; needs nothing else.
`timescale 1ns / 1ps
module gas_sensor_alcohol_converter_tb;

  localparam int unsigned GroupSize = 8;
  localparam int unsigned AdcMax = 1023;
  localparam logic [alc_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd2;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Sample side.
  logic          s_valid = 1'b0;
  logic [15:0]   s_data = '0;       // [9:0] adc_sample
  wire           s_ready;
  // Result side.
  wire           m_valid;
  logic          m_ready = 1'b0;
  wire  [127:0]  m_data;            // rs, ratio, ppm, mg/L, BAC, status
  // Register writes.
  logic                        cfg_valid = 1'b0;
  wire                         cfg_ready;
  logic [alc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [23:0]                 cfg_data = '0;

  gas_sensor_alcohol_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the registers and of the running sum.
  logic [alc_pkg::R0W-1:0]  clean_air_q = alc_pkg::R0_RESET;
  logic [alc_pkg::RlW-1:0]  load_q = alc_pkg::RL_RESET;
  logic [alc_pkg::SumW-1:0] sum_acc = '0;
  int unsigned              sum_cnt = 0;

  logic [alc_pkg::SampleW-1:0] sample_q[$];   // samples waiting to be sent
  alc_pkg::result_t            result_q[$];   // predicted results not yet seen

  bit failed = 1'b0;
  bit burst = 1'b0;                  // when set, the sender adds no random gaps
  bit in_taken = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned rx_wait = 0;
  int unsigned long_hold = 0;
  bit long_hold_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n_in);
    longint unsigned n, res, b;
    n = n_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q16 log2 by normalization and repeated squaring.
  function automatic longint log2_fixed(longint unsigned r);
    int e;
    longint unsigned m;
    longint fr;
    e = 63;
    fr = 0;
    while (r[e] == 1'b0) e--;
    m = (e >= 31) ? (r >> (e - 31)) : (r << (31 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        fr = fr | (64'd1 << (15 - i));
      end
    end
    return longint'(e - 16) * 65536 + fr;
  endfunction

  // 2^(fr/65536) in Q1.30 from a chain of square roots of two.
  function automatic longint unsigned exp2_frac(int unsigned fr);
    longint unsigned p, f;
    p = 64'd1 << 30;
    f = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      f = int_sqrt(f << 30);
      if ((fr >> (16 - k)) & 1) p = (p * f) >> 30;
    end
    return p;
  endfunction

  function automatic logic [alc_pkg::FieldW-1:0] clip24(longint unsigned v, ref bit sat);
    if (v > 64'hFFFFFF) begin
      sat = 1'b1;
      return alc_pkg::MAX24;
    end
    return v[alc_pkg::FieldW-1:0];
  endfunction

  // One result from a finished sample sum and the current registers.
  function automatic alc_pkg::result_t convert_sum(logic [alc_pkg::SumW-1:0] sum);
    alc_pkg::result_t res;
    longint unsigned num, sub, rs, r0, ratio, ppm, p;
    longint t, rnd, z;
    bit sat, big;
    sat = 1'b0;
    big = 1'b0;
    ppm = 0;
    if (sum == 0) begin
      res = '{alc_pkg::MAX24, alc_pkg::MAX24, '0, '0, '0, alc_pkg::ST_ZERO};
      return res;
    end
    num = longint'(AdcMax) * load_q * GroupSize;
    sub = longint'(load_q) * sum;
    if (num < sub) begin
      rs = 0;
      sat = 1'b1;
    end else begin
      rs = (num - sub) / sum;
    end
    r0 = (clean_air_q == 0) ? 1 : clean_air_q;
    ratio = (rs << 16) / r0;
    if (ratio == 0) begin
      big = 1'b1;
    end else begin
      // Rounding of the exponent product is half away from zero.
      t = 72745 * log2_fixed(ratio);
      rnd = (t >= 0) ? (t + 32768) / 65536 : -(((-t) + 32768) / 65536);
      z = 146320 - rnd + 8 * 65536;
      if (z >= 40 * 65536) begin
        big = 1'b1;
      end else if (z >= 0) begin
        p = exp2_frac(int'(z % 65536));
        ppm = (z / 65536 <= 30) ? (p >> (30 - z / 65536)) : (p << (z / 65536 - 30));
      end
    end
    res.rs_ohms = clip24(rs, sat);
    res.ratio_q16 = clip24(ratio, sat);
    if (big) begin
      sat = 1'b1;
      res.ppm_q8 = alc_pkg::MAX24;
      res.mg_per_litre_q16 = alc_pkg::MAX24;
      res.blood_alcohol_q16 = alc_pkg::MAX24;
    end else begin
      res.ppm_q8 = clip24(ppm, sat);
      res.mg_per_litre_q16 = clip24(ppm * 64 / 125, sat);
      res.blood_alcohol_q16 = clip24(ppm * 128 / 125, sat);
    end
    res.status = sat ? alc_pkg::ST_SAT : alc_pkg::ST_OK;
    return res;
  endfunction

  // Sender: one new sample after each accepted transfer, after a random gap unless burst is set.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_valid && !in_taken)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_valid <= 1'b1;
        s_data <= {6'd0, sample_q.pop_front()};
        gap_cnt <= burst ? 0 : $urandom_range(0, 6);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold that lets the input queue fill up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        m_ready <= 1'b0;
      end else if (!long_hold_done && results_seen == 30) begin
        long_hold_done <= 1'b1;
        long_hold <= 3000;
        m_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each sample transfer and checks each result transfer.
  always @(posedge clk_i) begin
    alc_pkg::result_t want, got;
    in_taken <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) begin
      sum_acc = sum_acc + s_data[alc_pkg::SampleW-1:0];
      sum_cnt++;
      if (sum_cnt == GroupSize) begin
        result_q.push_back(convert_sum(sum_acc));
        sum_acc = '0;
        sum_cnt = 0;
      end
    end
    if (rst_ni && m_valid && m_ready) begin
      results_seen <= results_seen + 1;
      rx_wait <= burst ? 0 : $urandom_range(0, 6);
      got.rs_ohms = m_data[23:0];
      got.ratio_q16 = m_data[47:24];
      got.ppm_q8 = m_data[71:48];
      got.mg_per_litre_q16 = m_data[95:72];
      got.blood_alcohol_q16 = m_data[119:96];
      got.status = m_data[121:120];
      if (result_q.size() == 0) begin
        $error("result transfer with no result expected");
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (got.rs_ohms !== want.rs_ohms) begin
          $error("rs_ohms: expected %0d, got %0d", want.rs_ohms, got.rs_ohms);
          failed = 1'b1;
        end
        if (got.ratio_q16 !== want.ratio_q16) begin
          $error("ratio_q16: expected %0d, got %0d", want.ratio_q16, got.ratio_q16);
          failed = 1'b1;
        end
        if (got.ppm_q8 !== want.ppm_q8) begin
          $error("ppm_q8: expected %0d, got %0d", want.ppm_q8, got.ppm_q8);
          failed = 1'b1;
        end
        if (got.mg_per_litre_q16 !== want.mg_per_litre_q16) begin
          $error("mg_per_litre_q16: expected %0d, got %0d", want.mg_per_litre_q16,
                 got.mg_per_litre_q16);
          failed = 1'b1;
        end
        if (got.blood_alcohol_q16 !== want.blood_alcohol_q16) begin
          $error("blood_alcohol_q16: expected %0d, got %0d", want.blood_alcohol_q16,
                 got.blood_alcohol_q16);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("gas_sensor_alcohol_converter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [alc_pkg::CfgIdxW-1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    // Mirror the write in the predictor; indexes past the list are dropped.
    if (idx == alc_pkg::CFG_CLEAN_AIR) clean_air_q = val;
    else if (idx == alc_pkg::CFG_LOAD) load_q = val[alc_pkg::RlW-1:0];
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Sender pauses until every predicted result has arrived and the back end is quiet.
  task automatic drain();
    wait (sample_q.size() == 0 && !s_valid && sum_cnt == 0 && result_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_group(int unsigned level, int unsigned spread);
    int v;
    for (int i = 0; i < GroupSize; i++) begin
      v = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      sample_q.push_back(v[alc_pkg::SampleW-1:0]);
    end
  endtask

  initial begin
    logic [23:0] r0_set[8];
    logic [23:0] rl_set[8];
    int unsigned mode;
    r0_set = '{24'd60000, 24'd1, 24'hFFFFFF, 24'd0, 24'd3000, 24'd60000, 24'd400000, 24'd12};
    rl_set = '{24'd200000, 24'd1, 24'hFFFFF, 24'd10000, 24'd200000, 24'hFFFFFF,
               24'd4700, 24'd100};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed groups at reset values: zero sum, full scale (rs comes out zero and
    // the ratio vanishes), all ones (rs saturates), and an alternating bit pattern.
    push_group(0, 0);
    push_group(1023, 0);
    push_group(1, 0);
    for (int i = 0; i < GroupSize; i++) sample_q.push_back(i[0] ? 10'h155 : 10'h2AA);
    drain();
    // A write to an index past the register list must change nothing.
    write_reg(CFG_UNUSED, 24'h123456);
    push_group(512, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(alc_pkg::CFG_CLEAN_AIR, r0_set[ph]);
      write_reg(alc_pkg::CFG_LOAD, rl_set[ph]);
      burst = (ph == 2 || ph == 5);
      for (int g = 0; g < 19; g++) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) push_group($urandom_range(0, 1023), 1023);
        else if (mode == 1) push_group($urandom_range(0, 3), 2);
        else if (mode == 2) push_group($urandom_range(1000, 1023), 23);
        else push_group($urandom_range(0, 1023), $urandom_range(0, 40));
      end
      drain();
    end

    if (!failed) begin
      $display("gas_sensor_alcohol_converter regression: pass");
    end else begin
      $display("gas_sensor_alcohol_converter regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/alc_pkg.sv
hw/rtl/alc_front.sv
hw/rtl/alc_fifo.sv
hw/rtl/alc_div.sv
hw/rtl/alc_back.sv
hw/rtl/gas_sensor_alcohol_converter.sv
tb/gas_sensor_alcohol_converter_tb.sv
